// ===== hdl/nci_pkg.sv =====
package nci_pkg;

	// item codes on the mode field
	typedef enum logic [1:0] {
		MODE_TRACK = 2'd0,
		MODE_PROTO = 2'd1,
		MODE_READ  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CONES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONE_MAX  = 2'd1;

	localparam logic [3:0] NUM_CONES_RST = 4'd3;
	localparam logic [3:0] CONE_MAX_RST  = 4'd1;

	// ghost probability marking a missing value (999.0 with 8 fraction bits)
	localparam logic [17:0] GHOST_MISSING = 18'd255744;

	// per-cone running sums, count kept apart
	typedef struct packed {
		logic [23:0] st;
		logic [15:0] meas;
		logic [25:0] ghost;
		logic [31:0] lik;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] ecal;
		logic [31:0] hcal;
	} sums_t;

	// update word as held for the duration of an item
	typedef struct packed {
		logic        proto;
		logic [2:0]  flags;
		logic [7:0]  meas;
		logic [17:0] ghost;
		logic [23:0] lik;
		logic [23:0] px;
		logic [23:0] py;
		logic [23:0] pz;
		logic [23:0] ecal;
		logic [23:0] hcal;
	} item_t;

endpackage

// ===== hdl/nested_cone_isolation_accumulator_core.sv =====
// Nested cone isolation accumulator. Per-cone sums live in one memory with a
// registered read; an update or readout word walks the n cones in use with one
// read per cycle, and an update writes each cone back the cycle after its read,
// so busy stays high from start until the last cone's read data is back (n =
// num_cones clamped to 1..MAX_CONES). A clear word does not raise busy. Readout
// results appear one per cycle on strobe, registered after the memory read, last flagged; the receiver
// cannot hold them off, so they must be taken as they come. Configuration is
// written while busy is low. Reset needs no clearing pass: per-entry valid bits
// make every cone read as zero until first written.
module nested_cone_isolation_accumulator_core #(
	parameter int MAX_CONES  = 9,
	parameter int COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] distance,
	input  logic [2:0]  station_flags,
	input  logic [7:0]  measurements,
	input  logic [17:0] ghost_prob,
	input  logic signed [23:0] likelihood,
	input  logic signed [23:0] mom_x,
	input  logic signed [23:0] mom_y,
	input  logic signed [23:0] mom_z,
	input  logic [23:0] ecal_energy,
	input  logic [23:0] hcal_energy,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nci_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [3:0]                    cfg_data,
	// results
	output logic        strobe,
	output logic [3:0]  cone_index,
	output logic [7:0]  track_count,
	output logic [23:0] station_counts,
	output logic [15:0] meas_sum,
	output logic [25:0] ghost_sum,
	output logic signed [31:0] likelihood_sum,
	output logic signed [31:0] sum_x,
	output logic signed [31:0] sum_y,
	output logic signed [31:0] sum_z,
	output logic [63:0] calo_sums,
	output logic        last
);

	localparam int IDX_W = (MAX_CONES > 1) ? $clog2(MAX_CONES) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	nci_pkg::state_t state_q, state_d;

	logic [3:0]  num_cones_q;
	logic [3:0]  cone_max_q;
	logic [3:0]  n_use;
	logic        accept;
	logic        run_done;
	logic        rd_en;
	logic        clr;

	nci_pkg::mode_t mode_q;
	nci_pkg::item_t item_q;
	logic [19:0] dist_n_q;
	logic [3:0]  n_q;
	logic [3:0]  idx_q;

	logic [7:0]  rad_units;
	logic [19:0] rad_s;
	logic        in_cone;

	logic        s1_vld;
	logic [3:0]  s1_idx;
	logic        s1_last;
	logic        s1_inside;

	logic [COUNT_BITS-1:0] rd_cnt, wr_cnt;
	nci_pkg::sums_t        rd_sums, wr_sums;
	logic                  wr_en;
	logic                  is_upd;
	logic [COUNT_BITS+7:0] cnt_ext;

	// cones in use, zero acting as one and clamped to the memory depth
	always_comb begin
		if (num_cones_q == 4'd0) begin
			n_use = 4'd1;
		end else if ({1'b0, num_cones_q} > 5'(MAX_CONES)) begin
			n_use = 4'(MAX_CONES);
		end else begin
			n_use = num_cones_q;
		end
	end

	assign busy      = (state_q != nci_pkg::ST_IDLE) || s1_vld;
	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign run_done  = (idx_q == n_q - 4'd1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cones_q <= nci_pkg::NUM_CONES_RST;
			cone_max_q  <= nci_pkg::CONE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nci_pkg::REG_NUM_CONES: num_cones_q <= cfg_data;
				nci_pkg::REG_CONE_MAX:  cone_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nci_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		clr     = 1'b0;
		unique case (state_q)
			nci_pkg::ST_IDLE: begin
				if (accept) begin
					if (nci_pkg::mode_t'(mode) == nci_pkg::MODE_CLEAR) begin
						clr = 1'b1;
					end else begin
						state_d = nci_pkg::ST_RUN;
					end
				end
			end
			nci_pkg::ST_RUN: begin
				rd_en = 1'b1;
				if (run_done) begin
					state_d = nci_pkg::ST_IDLE;
				end
			end
			default: state_d = nci_pkg::ST_IDLE;
		endcase
	end

	// word capture and cone counter
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q         <= nci_pkg::mode_t'(mode);
			item_q.proto   <= (nci_pkg::mode_t'(mode) == nci_pkg::MODE_PROTO);
			item_q.flags   <= station_flags;
			item_q.meas    <= measurements;
			item_q.ghost   <= ghost_prob;
			item_q.lik     <= likelihood;
			item_q.px      <= mom_x;
			item_q.py      <= mom_y;
			item_q.pz      <= mom_z;
			item_q.ecal    <= ecal_energy;
			item_q.hcal    <= hcal_energy;
			dist_n_q       <= 20'(distance) * 20'(n_use);
			n_q            <= n_use;
			idx_q          <= 4'd0;
		end else if (rd_en) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	// inside test: distance*n < cone_max*(n-i)*4096
	assign rad_units = 8'(cone_max_q) * 8'(n_q - idx_q);
	assign rad_s     = {rad_units, 12'h000};
	assign in_cone   = dist_n_q < rad_s;

	// stage 1: read data back from memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else begin
			s1_vld <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			s1_idx    <= idx_q;
			s1_last   <= run_done;
			s1_inside <= in_cone;
		end
	end

	nci_mem #(
		.DEPTH (MAX_CONES),
		.IDX_W (IDX_W),
		.CNT_W (COUNT_BITS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.rd_en   (rd_en),
		.rd_addr (idx_q[IDX_W-1:0]),
		.wr_en   (wr_en),
		.wr_addr (s1_idx[IDX_W-1:0]),
		.wr_cnt  (wr_cnt),
		.wr_sums (wr_sums),
		.rd_cnt  (rd_cnt),
		.rd_sums (rd_sums)
	);

	nci_alu #(
		.CNT_W (COUNT_BITS)
	) u_alu (
		.cnt_in   (rd_cnt),
		.sums_in  (rd_sums),
		.item     (item_q),
		.cnt_out  (wr_cnt),
		.sums_out (wr_sums)
	);

	// write back only inside the cone and below the count limit
	assign is_upd = (mode_q == nci_pkg::MODE_TRACK) || (mode_q == nci_pkg::MODE_PROTO);
	assign wr_en  = s1_vld && is_upd && s1_inside && (rd_cnt != CNT_MAX);

	// result register
	assign cnt_ext = {8'b0, rd_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= s1_vld && (mode_q == nci_pkg::MODE_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld && (mode_q == nci_pkg::MODE_READ)) begin
			cone_index     <= s1_idx;
			track_count    <= cnt_ext[7:0];
			station_counts <= rd_sums.st;
			meas_sum       <= rd_sums.meas;
			ghost_sum      <= rd_sums.ghost;
			likelihood_sum <= rd_sums.lik;
			sum_x          <= rd_sums.px;
			sum_y          <= rd_sums.py;
			sum_z          <= rd_sums.pz;
			calo_sums      <= {rd_sums.hcal, rd_sums.ecal};
			last           <= s1_last;
		end
	end

endmodule

// ===== hdl/nci_mem.sv =====
module nci_mem #(
	parameter int DEPTH = 9,
	parameter int IDX_W = 4,
	parameter int CNT_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [CNT_W-1:0]     wr_cnt,
	input  nci_pkg::sums_t       wr_sums,
	output logic [CNT_W-1:0]     rd_cnt,
	output nci_pkg::sums_t       rd_sums
);

	logic [CNT_W-1:0] mem_cnt [DEPTH];
	nci_pkg::sums_t   mem_sums [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;
	logic [CNT_W-1:0] rd_cnt_q;
	nci_pkg::sums_t   rd_sums_q;

	// storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_cnt[wr_addr]  <= wr_cnt;
			mem_sums[wr_addr] <= wr_sums;
		end
		if (rd_en) begin
			rd_cnt_q  <= mem_cnt[rd_addr];
			rd_sums_q <= mem_sums[rd_addr];
		end
	end

	// entry valid bits; an entry never written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_cnt  = rd_vld_q ? rd_cnt_q : '0;
	assign rd_sums = rd_vld_q ? rd_sums_q : '0;

endmodule

// ===== hdl/nci_alu.sv =====
module nci_alu #(
	parameter int CNT_W = 8
) (
	input  logic [CNT_W-1:0] cnt_in,
	input  nci_pkg::sums_t   sums_in,
	input  nci_pkg::item_t   item,
	output logic [CNT_W-1:0] cnt_out,
	output nci_pkg::sums_t   sums_out
);

	// signed 32-bit add of a 24-bit term, clamped at the 32-bit limits
	function automatic logic [31:0] add_ssat(input logic [31:0] a, input logic [23:0] b);
		logic [32:0] s;
		s = {a[31], a} + {{9{b[23]}}, b};
		if (s[32] != s[31]) begin
			return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return s[31:0];
	endfunction

	// unsigned 32-bit add of a 24-bit term, clamped at all ones
	function automatic logic [31:0] add_usat32(input logic [31:0] a, input logic [23:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {9'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	logic [16:0] meas_s;
	logic [26:0] ghost_s;
	logic        ghost_add;
	logic [8:0]  st_s [3];

	always_comb begin
		cnt_out  = cnt_in + CNT_W'(1);
		sums_out = sums_in;

		// station counts, each byte saturating
		for (int k = 0; k < 3; k++) begin
			st_s[k] = {1'b0, sums_in.st[8*k +: 8]} + {8'b0, item.flags[k]};
			sums_out.st[8*k +: 8] = st_s[k][8] ? 8'hFF : st_s[k][7:0];
		end

		meas_s = {1'b0, sums_in.meas} + {9'b0, item.meas};
		sums_out.meas = meas_s[16] ? 16'hFFFF : meas_s[15:0];

		// track items skip the missing-ghost marker, proto items do not
		ghost_add = item.proto || (item.ghost != nci_pkg::GHOST_MISSING);
		ghost_s   = {1'b0, sums_in.ghost} + {9'b0, item.ghost};
		if (ghost_add) begin
			sums_out.ghost = ghost_s[26] ? 26'h3FF_FFFF : ghost_s[25:0];
		end

		sums_out.lik = add_ssat(sums_in.lik, item.lik);
		sums_out.px  = add_ssat(sums_in.px, item.px);
		sums_out.py  = add_ssat(sums_in.py, item.py);
		sums_out.pz  = add_ssat(sums_in.pz, item.pz);

		if (item.proto) begin
			sums_out.ecal = add_usat32(sums_in.ecal, item.ecal);
			sums_out.hcal = add_usat32(sums_in.hcal, item.hcal);
		end
	end

endmodule

// ===== tb/sv/nci_tb_pkg.sv =====
package nci_tb_pkg;

	import nci_pkg::*;

	localparam int CONES     = 9;
	localparam int COUNT_TOP = 255;

	// one command word as presented on the input ports
	typedef struct {
		mode_t              mode;
		logic [15:0]        distance;
		logic [2:0]         flags;
		logic [7:0]         meas;
		logic [17:0]        ghost;
		logic signed [23:0] lik;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic [23:0]        ecal;
		logic [23:0]        hcal;
	} cmd_word_t;

	// one per-cone report word
	typedef struct {
		logic [3:0]  cone_index;
		logic [7:0]  track_count;
		logic [23:0] station_counts;
		logic [15:0] meas_sum;
		logic [25:0] ghost_sum;
		logic [31:0] lik_sum;
		logic [31:0] sum_x;
		logic [31:0] sum_y;
		logic [31:0] sum_z;
		logic [63:0] calo_sums;
		logic        last;
	} cone_report_t;

	class cone_isolation_scoreboard;

		bit [3:0]    num_cones_cfg;
		bit [3:0]    cone_max_cfg;
		int          track_cnt [CONES];
		bit [23:0]   station_cnt [CONES];
		longint      meas_acc [CONES];
		longint      ghost_acc [CONES];
		longint      lik_acc [CONES];
		longint      px_acc [CONES];
		longint      py_acc [CONES];
		longint      pz_acc [CONES];
		longint      ecal_acc [CONES];
		longint      hcal_acc [CONES];
		cone_report_t expected_reports[$];
		int          errors;

		function new();
			num_cones_cfg = NUM_CONES_RST;
			cone_max_cfg  = CONE_MAX_RST;
			errors        = 0;
			clear_cones();
		endfunction

		function void clear_cones();
			for (int i = 0; i < CONES; i++) begin
				track_cnt[i]   = 0;
				station_cnt[i] = '0;
				meas_acc[i]    = 0;
				ghost_acc[i]   = 0;
				lik_acc[i]     = 0;
				px_acc[i]      = 0;
				py_acc[i]      = 0;
				pz_acc[i]      = 0;
				ecal_acc[i]    = 0;
				hcal_acc[i]    = 0;
			end
		endfunction

		function int cones_used();
			if (num_cones_cfg == 0)
				return 1;
			if (num_cones_cfg > CONES)
				return CONES;
			return num_cones_cfg;
		endfunction

		function longint sat_add_u(longint a, longint b, longint top);
			longint s;
			s = a + b;
			return (s > top) ? top : s;
		endfunction

		function longint sat_add_s(longint a, longint b);
			longint s;
			s = a + b;
			if (s > 64'sd2147483647)
				return 64'sd2147483647;
			if (s < -64'sd2147483648)
				return -64'sd2147483648;
			return s;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] data);
			if (idx == REG_NUM_CONES)
				num_cones_cfg = data;
			else if (idx == REG_CONE_MAX)
				cone_max_cfg = data;
		endfunction

		// add one track or proto word to every cone whose radius exceeds its distance
		function void add_to_cones(cmd_word_t c, bit proto);
			int     n;
			longint radius_scaled;
			bit [7:0] f;
			n = cones_used();
			for (int i = 0; i < n; i++) begin
				radius_scaled = longint'(cone_max_cfg) * (n - i) * 4096;
				if (!(longint'(c.distance) * n < radius_scaled))
					continue;
				// a full cone is frozen
				if (track_cnt[i] >= COUNT_TOP)
					continue;
				track_cnt[i]++;
				for (int k = 0; k < 3; k++) begin
					f = station_cnt[i][8*k +: 8];
					if (c.flags[k] && f != 8'hFF)
						f++;
					station_cnt[i][8*k +: 8] = f;
				end
				meas_acc[i] = sat_add_u(meas_acc[i], longint'(c.meas), 64'hFFFF);
				// missing ghost value is only skipped for tracks
				if (proto || c.ghost != GHOST_MISSING)
					ghost_acc[i] = sat_add_u(ghost_acc[i], longint'(c.ghost), 64'h3FFFFFF);
				lik_acc[i] = sat_add_s(lik_acc[i], longint'(c.lik));
				px_acc[i]  = sat_add_s(px_acc[i], longint'(c.px));
				py_acc[i]  = sat_add_s(py_acc[i], longint'(c.py));
				pz_acc[i]  = sat_add_s(pz_acc[i], longint'(c.pz));
				if (proto) begin
					ecal_acc[i] = sat_add_u(ecal_acc[i], longint'(c.ecal), 64'hFFFFFFFF);
					hcal_acc[i] = sat_add_u(hcal_acc[i], longint'(c.hcal), 64'hFFFFFFFF);
				end
			end
		endfunction

		// queue one report per cone in use
		function void report_cones();
			cone_report_t r;
			int n;
			n = cones_used();
			for (int i = 0; i < n; i++) begin
				r.cone_index     = 4'(i);
				r.track_count    = 8'(track_cnt[i]);
				r.station_counts = station_cnt[i];
				r.meas_sum       = meas_acc[i][15:0];
				r.ghost_sum      = ghost_acc[i][25:0];
				r.lik_sum        = lik_acc[i][31:0];
				r.sum_x          = px_acc[i][31:0];
				r.sum_y          = py_acc[i][31:0];
				r.sum_z          = pz_acc[i][31:0];
				r.calo_sums      = {hcal_acc[i][31:0], ecal_acc[i][31:0]};
				r.last           = (i + 1 == n);
				expected_reports = {expected_reports, r};
			end
		endfunction

		function void note_word(cmd_word_t c);
			case (c.mode)
				MODE_TRACK: add_to_cones(c, 1'b0);
				MODE_PROTO: add_to_cones(c, 1'b1);
				MODE_READ:  report_cones();
				MODE_CLEAR: clear_cones();
				default:    ;
			endcase
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void fail_note(string what);
			errors++;
			if (errors <= 10)
				$display("%0t result error: %s", $realtime, what);
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got)
				fail_note($sformatf("%s expected %h got %h", name, want, got));
		endfunction

		function void check_result(cone_report_t got);
			cone_report_t want;
			if (expected_reports.size() == 0) begin
				fail_note($sformatf("unexpected report for cone %0d", got.cone_index));
				return;
			end
			want = expected_reports.pop_front();
			cmp_field("cone_index", want.cone_index, got.cone_index);
			cmp_field("track_count", want.track_count, got.track_count);
			cmp_field("station_counts", want.station_counts, got.station_counts);
			cmp_field("meas_sum", want.meas_sum, got.meas_sum);
			cmp_field("ghost_sum", want.ghost_sum, got.ghost_sum);
			cmp_field("likelihood_sum", want.lik_sum, got.lik_sum);
			cmp_field("sum_x", want.sum_x, got.sum_x);
			cmp_field("sum_y", want.sum_y, got.sum_y);
			cmp_field("sum_z", want.sum_z, got.sum_z);
			cmp_field("calo_sums", want.calo_sums, got.calo_sums);
			cmp_field("last", want.last, got.last);
		endfunction

		// anything still queued at the end never arrived
		function void flush_leftover();
			while (expected_reports.size() != 0) begin
				fail_note($sformatf("report for cone %0d never arrived",
					expected_reports[0].cone_index));
				void'(expected_reports.pop_front());
			end
		endfunction

	endclass

endpackage

// ===== tb/sv/tb.sv =====
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import nci_pkg::*;
	import nci_tb_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	mode_t                mode;
	logic [15:0]          distance;
	logic [2:0]           station_flags;
	logic [7:0]           measurements;
	logic [17:0]          ghost_prob;
	logic signed [23:0]   likelihood;
	logic signed [23:0]   mom_x;
	logic signed [23:0]   mom_y;
	logic signed [23:0]   mom_z;
	logic [23:0]          ecal_energy;
	logic [23:0]          hcal_energy;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [3:0]           cfg_data;
	logic                 strobe;
	logic [3:0]           cone_index;
	logic [7:0]           track_count;
	logic [23:0]          station_counts;
	logic [15:0]          meas_sum;
	logic [25:0]          ghost_sum;
	logic signed [31:0]   likelihood_sum;
	logic signed [31:0]   sum_x;
	logic signed [31:0]   sum_y;
	logic signed [31:0]   sum_z;
	logic [63:0]          calo_sums;
	logic                 last;

	cone_isolation_scoreboard sb;
	int                       burst_left;
	bit [3:0]                 cur_cone_max;

	nested_cone_isolation_accumulator_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// observe accepted words, config writes and reports
	always @(posedge clk) begin
		cmd_word_t    c;
		cone_report_t r;
		if (arst_n) begin
			if (strobe) begin
				r.cone_index     = cone_index;
				r.track_count    = track_count;
				r.station_counts = station_counts;
				r.meas_sum       = meas_sum;
				r.ghost_sum      = ghost_sum;
				r.lik_sum        = likelihood_sum;
				r.sum_x          = sum_x;
				r.sum_y          = sum_y;
				r.sum_z          = sum_z;
				r.calo_sums      = calo_sums;
				r.last           = last;
				sb.check_result(r);
			end
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (start && !busy) begin
				c.mode     = mode;
				c.distance = distance;
				c.flags    = station_flags;
				c.meas     = measurements;
				c.ghost    = ghost_prob;
				c.lik      = likelihood;
				c.px       = mom_x;
				c.py       = mom_y;
				c.pz       = mom_z;
				c.ecal     = ecal_energy;
				c.hcal     = hcal_energy;
				sb.note_word(c);
			end
		end
	end

	function automatic cmd_word_t make_word(mode_t m, logic [15:0] d, logic [2:0] fl,
			logic [7:0] ms, logic [17:0] gh, logic [23:0] lk, logic [23:0] x,
			logic [23:0] y, logic [23:0] z, logic [23:0] ec, logic [23:0] hc);
		cmd_word_t c;
		c.mode = m; c.distance = d; c.flags = fl; c.meas = ms; c.ghost = gh;
		c.lik = lk; c.px = x; c.py = y; c.pz = z; c.ecal = ec; c.hcal = hc;
		return c;
	endfunction

	// random word; distances mostly land near the cones in use
	function automatic cmd_word_t random_word(bit updates_only);
		cmd_word_t c;
		int        pick;
		pick = updates_only ? $urandom_range(0, 79) : $urandom_range(0, 99);
		if (pick < 42)
			c.mode = MODE_TRACK;
		else if (pick < 80)
			c.mode = MODE_PROTO;
		else if (pick < 96)
			c.mode = MODE_READ;
		else
			c.mode = MODE_CLEAR;
		if ($urandom_range(0, 3) == 0)
			c.distance = 16'($urandom());
		else
			c.distance = 16'($urandom_range(0, (cur_cone_max == 0) ? 4096 :
				int'(cur_cone_max) * 4096 - 1));
		c.flags = 3'($urandom());
		c.meas  = 8'($urandom());
		case ($urandom_range(0, 5))
			0:       c.ghost = GHOST_MISSING;
			1, 2:    c.ghost = 18'($urandom_range(0, 1023));
			default: c.ghost = 18'($urandom());
		endcase
		c.lik  = 24'($urandom());
		c.px   = 24'($urandom());
		c.py   = 24'($urandom());
		c.pz   = 24'($urandom());
		c.ecal = 24'($urandom());
		c.hcal = 24'($urandom());
		return c;
	endfunction

	// present one word; start stays high across a burst
	task automatic send_word(cmd_word_t c);
		int gap;
		@(negedge clk);
		mode          = c.mode;
		distance      = c.distance;
		station_flags = c.flags;
		measurements  = c.meas;
		ghost_prob    = c.ghost;
		likelihood    = c.lik;
		mom_x         = c.px;
		mom_y         = c.py;
		mom_z         = c.pz;
		ecal_energy   = c.ecal;
		hcal_energy   = c.hcal;
		start         = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				start = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// wait until every report is in and the block has settled
	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		start = 1'b0;
		while ((sb.pending() != 0 || busy) && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (12) @(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [3:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_cones(bit [3:0] n, bit [3:0] cmax);
		drain();
		if ($urandom_range(0, 1)) begin
			write_cfg(REG_NUM_CONES, n);
			write_cfg(REG_CONE_MAX, cmax);
		end else begin
			write_cfg(REG_CONE_MAX, cmax);
			write_cfg(REG_NUM_CONES, n);
		end
		cur_cone_max = cmax;
	endtask

	initial begin
		bit [3:0] cfg_n [5];
		bit [3:0] cfg_cm [5];
		cfg_n         = '{4'd9, 4'd1, 4'd15, 4'd0, 4'd5};
		cfg_cm        = '{4'd15, 4'd0, 4'd8, 4'd15, 4'd3};
		sb            = new();
		arst_n        = 1'b0;
		start         = 1'b0;
		mode          = MODE_TRACK;
		distance      = '0;
		station_flags = '0;
		measurements  = '0;
		ghost_prob    = '0;
		likelihood    = '0;
		mom_x         = '0;
		mom_y         = '0;
		mom_z         = '0;
		ecal_energy   = '0;
		hcal_energy   = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_NUM_CONES;
		cfg_data      = '0;
		burst_left    = 3;
		cur_cone_max  = CONE_MAX_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings are three cones of unit radius
		send_word(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(MODE_TRACK, 0, 3'h7, 8'hFF, 18'h3FFFF, 24'h7FFFFF,
			24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
		// missing ghost value is skipped on a track
		send_word(make_word(MODE_TRACK, 0, 0, 0, GHOST_MISSING, 24'h800000,
			0, 0, 0, 0, 0));
		// ...but summed on a proto
		send_word(make_word(MODE_PROTO, 0, 3'h1, 8'h01, GHOST_MISSING, 24'h000001,
			24'h000001, 24'hFFFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF));
		// edges of the innermost and outermost cones
		send_word(make_word(MODE_PROTO, 16'd1365, 3'h2, 8'd7, 18'd100, 24'h000100,
			24'h000010, 24'h000020, 24'h000030, 24'h000001, 24'h000002));
		send_word(make_word(MODE_TRACK, 16'd1366, 3'h4, 8'd9, 18'd5, 24'hFFFF00,
			24'h000011, 24'h000022, 24'h000033, 24'h000003, 24'h000004));
		send_word(make_word(MODE_PROTO, 16'd4095, 3'h5, 8'd3, 18'd7, 24'h123456,
			24'h654321, 24'h0F0F0F, 24'hF0F0F0, 24'hABCDEF, 24'h555555));
		send_word(make_word(MODE_TRACK, 16'd4096, 3'h7, 8'hFF, 18'd1, 24'h000001,
			0, 0, 0, 0, 0));
		send_word(make_word(MODE_PROTO, 16'hFFFF, 3'h7, 8'hFF, 18'd1, 24'h000001,
			0, 0, 0, 24'h1, 24'h1));
		send_word(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		// zero radius, cone count of zero acting as one
		set_cones(4'd0, 4'd0);
		send_word(make_word(MODE_PROTO, 0, 3'h7, 8'd1, 18'd1, 24'h1, 24'h1, 24'h1,
			24'h1, 24'h1, 24'h1));
		send_word(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		// cone count above the maximum, widest radius
		set_cones(4'd15, 4'd15);
		send_word(make_word(MODE_TRACK, 0, 3'h3, 8'd20, 18'd300, 24'hFFFFFE,
			24'h000100, 24'h000200, 24'hFFFF00, 24'h0, 24'h0));
		send_word(make_word(MODE_PROTO, 16'd6826, 3'h6, 8'd4, 18'd50, 24'h000040,
			24'h100000, 24'hF00000, 24'h000001, 24'h0000FF, 24'hFF0000));
		send_word(make_word(MODE_PROTO, 16'd6827, 3'h1, 8'd4, 18'd50, 24'h000040,
			24'h100000, 24'hF00000, 24'h000001, 24'h0000FF, 24'hFF0000));
		send_word(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		// random phases, extremes first; sums carry over between settings
		for (int p = 0; p < 8; p++) begin
			if (p < 5)
				set_cones(cfg_n[p], cfg_cm[p]);
			else
				set_cones(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			repeat (16)
				send_word(random_word(1'b0));
			send_word(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		end

		drain();
		sb.flush_leftover();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/nci_pkg.sv
hdl/nci_mem.sv
hdl/nci_alu.sv
hdl/nested_cone_isolation_accumulator_core.sv
tb/sv/nci_tb_pkg.sv
tb/sv/tb.sv
